// ===== sv/mwc_random_in_range_defines.svh =====
// Assertion macros shared by the checker of the random range generator.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef MWC_RANDOM_IN_RANGE_DEFINES_SVH
`define MWC_RANDOM_IN_RANGE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MWC_ASSERT_NOW(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MWC_ASSERT_NEXT(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mwc_pkg.sv =====
// Types and constants of the multiply-with-carry random range generator.
// No dependencies; used by the top level and its checker.
package mwc_pkg;

	localparam int WORD_W      = 32;
	localparam int HALF_W      = 16;
	localparam int CFG_INDEX_W = 2;

	// Multipliers of the two generator halves.
	localparam logic [HALF_W-1:0] Z_MULT = 16'd36969;
	localparam logic [HALF_W-1:0] W_MULT = 16'd18000;

	localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_SEED_Z = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SEED_W = 2'd1;

	typedef struct packed {
		logic [WORD_W-1:0] low_bound;
		logic [WORD_W-1:0] high_bound;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] raw_word;
	} out_word_t;

endpackage

// ===== sv/mwc_random_in_range.sv =====
// Multiply-with-carry random generator that answers each request with a value in a range.
// Depends on mwc_pkg for the word types and constants.

// Each accepted request advances the two 32-bit generator halves on one shared
// 16-by-16 constant multiplier (first z, then w), forms the raw word, and
// reduces it modulo the span high_bound - low_bound + 1 with a restoring
// remainder unit that retires one dividend bit per cycle. A request passes
// through the multiplier steps, the 32-bit remainder loop and a final step that
// adds the low bound and loads the output register. When the span wraps to zero
// (the full 32-bit range) the remainder loop is skipped. The block takes one
// request at a time and accepts the next one only after returning to idle.
// A finished result waits in the output register while the next request is
// accepted; the next result stays in its final step until the consumer takes
// the waiting word. Writing seed_z or seed_w while idle reloads that half
// directly; outside idle such writes have no effect.
module mwc_random_in_range
	import mwc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV_Z,
		ST_ADV_W,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	localparam int CNT_W = $clog2(WORD_W);

	state_t            state_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] w_q;
	logic [WORD_W-1:0] low_q;
	logic [WORD_W-1:0] span_q;
	logic [WORD_W-1:0] raw_q;
	logic [WORD_W-1:0] div_q;
	logic [WORD_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	// Shared multiplier of both halves.
	logic [WORD_W-1:0] mul_half;
	logic [HALF_W-1:0] mul_const;
	logic [WORD_W-1:0] mul_result;
	logic [WORD_W-1:0] raw_next;

	// Restoring remainder step.
	logic [WORD_W:0]   rem_shift;
	logic [WORD_W:0]   rem_diff;
	logic [WORD_W-1:0] rem_next;

	logic [WORD_W-1:0] span_in;

	always_comb begin
		mul_half   = (state_q == ST_ADV_Z) ? z_q : w_q;
		mul_const  = (state_q == ST_ADV_Z) ? Z_MULT : W_MULT;
		mul_result = WORD_W'({{HALF_W{1'b0}}, mul_const} * {{HALF_W{1'b0}}, mul_half[HALF_W-1:0]})
			+ {{HALF_W{1'b0}}, mul_half[WORD_W-1:HALF_W]};
		raw_next   = {z_q[HALF_W-1:0], {HALF_W{1'b0}}} + mul_result;

		rem_shift = {rem_q, div_q[WORD_W-1]};
		rem_diff  = rem_shift - {1'b0, span_q};
		rem_next  = rem_diff[WORD_W] ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];

		span_in = in_word.high_bound - in_word.low_bound + WORD_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			z_q         <= SEED_RESET;
			w_q         <= SEED_RESET;
			low_q       <= '0;
			span_q      <= '0;
			raw_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			cnt_q       <= '0;
		end else begin
			// The final step sets the valid flag itself when it loads a new word.
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_we && cfg_index == CFG_SEED_Z) begin
						z_q <= cfg_wdata;
					end
					if (cfg_we && cfg_index == CFG_SEED_W) begin
						w_q <= cfg_wdata;
					end
					if (in_valid) begin
						low_q   <= in_word.low_bound;
						span_q  <= span_in;
						state_q <= ST_ADV_Z;
					end
				end
				ST_ADV_Z: begin
					z_q     <= mul_result;
					state_q <= ST_ADV_W;
				end
				ST_ADV_W: begin
					w_q   <= mul_result;
					raw_q <= raw_next;
					div_q <= raw_next;
					cnt_q <= '0;
					// A span that wrapped to zero means the full range: no reduction.
					if (span_q == '0) begin
						rem_q   <= raw_next;
						state_q <= ST_FINISH;
					end else begin
						rem_q   <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					rem_q <= rem_next;
					div_q <= {div_q[WORD_W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORD_W - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_word_q.value    <= low_q + rem_q;
						out_word_q.raw_word <= raw_q;
						out_valid_q         <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ===== sv/mwc_checker.sv =====
// Port-level assertions for the random range generator, bound to its top level.
// Depends on mwc_pkg and the macros in mwc_random_in_range_defines.svh.
`include "mwc_random_in_range_defines.svh"

module mwc_checker
	import mwc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	// A result word waiting for the consumer must not change.
	`MWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "unstable")

	// Accepting a request makes the block busy without raising a new result.
	`MWC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !$rose(out_valid), "not busy")

	// A new result appears only as the block returns to idle.
	`MWC_ASSERT_NOW(a_result_frees_input, $rose(out_valid), in_ready, "busy at result")

	// The block only leaves idle by accepting a request.
	`MWC_ASSERT_NOW(a_busy_needs_request, $fell(in_ready), $past(in_valid), "busy without word")

endmodule

bind mwc_random_in_range mwc_checker u_mwc_checker (.*);
